[rtl/ffba_pkg.sv]
package ffba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] ST_REUSED    = 2'd0;
  localparam logic [1:0] ST_APPENDED  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic CFG_HEADER_BYTES = 1'b0;
  localparam logic CFG_HEAP_LIMIT   = 1'b1;

  localparam logic [7:0]  HEADER_RESET = 8'd24;
  localparam logic [31:0] LIMIT_RESET  = 32'd65536;

  typedef struct packed {
    logic [31:0] base;
    logic [23:0] length;
  } entry_t;

endpackage

[rtl/first_fit_block_allocator_unit.sv]
// first-fit heap block allocator with a table of up to MAX_BLOCKS blocks
// request channel: mode, request_size and release_address are taken at a clock
// edge where start is high and busy is low; busy stays high while the request
// is worked on
// result channel: done is high for one cycle with data_address and status;
// the receiver takes it in that cycle and cannot hold it off
// the block table sits in a one-port-write, one-port-read memory with a
// registered read; entries are read one per cycle in table order and
// checked in the cycle after, so a request ends at the first matching entry
// or after the last entry of the table walk
// a new request may be started in the cycle that done is high
// configuration: cfg_we writes header_bytes (index 0) or heap_limit (index 1)
// from cfg_data; write only while idle
// synchronous reset rst empties the table, clears the bump pointer and restores
// header_bytes 24 and heap_limit 65536; no memory clearing pass is needed
module first_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [23:0] request_size,
  input  logic [31:0] release_address,
  output logic        done,
  output logic [31:0] data_address,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t state;

  logic [7:0]  hdr_bytes;
  logic [31:0] heap_lim;

  logic [ffba_pkg::CNT_W-1:0]      blk_count;
  logic [31:0]                     bump_ptr;
  logic [ffba_pkg::MAX_BLOCKS-1:0] free_bits;

  logic        req_mode;
  logic [23:0] req_size;
  logic [31:0] req_addr;
  logic [33:0] req_end;

  logic [ffba_pkg::CNT_W-1:0] rd_idx;
  logic [ffba_pkg::IDX_W-1:0] chk_idx;
  logic                       chk_valid;

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_q;
  ffba_pkg::entry_t wr_data;

  logic        accept;
  logic        scanning;
  logic        more;
  logic        hit_alloc;
  logic        hit_free;
  logic        hit;
  logic        issue;
  logic        scan_miss;
  logic        table_full;
  logic        over_limit;
  logic        append_ok;
  logic [31:0] rd_data_addr;

  assign accept     = start && (state == IDLE);
  assign busy       = (state != IDLE);
  assign scanning   = (state == SCAN);
  assign more       = (rd_idx < blk_count);
  assign rd_data_addr = rd_q.base + {24'd0, hdr_bytes};
  assign hit_alloc  = chk_valid && !req_mode && free_bits[chk_idx] &&
                      (rd_q.length >= req_size);
  assign hit_free   = chk_valid && req_mode && (rd_data_addr == req_addr);
  assign hit        = scanning && (hit_alloc || hit_free);
  assign issue      = scanning && more && !hit;
  assign scan_miss  = scanning && !chk_valid && !more;
  assign table_full = (blk_count == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
  assign over_limit = (req_end > {2'b00, heap_lim});
  assign append_ok  = scan_miss && !req_mode && !table_full && !over_limit;
  assign wr_data    = '{base: bump_ptr, length: req_size};

  // block table memory
  always_ff @(posedge clk) begin
    if (append_ok) begin
      mem[blk_count[ffba_pkg::IDX_W-1:0]] <= wr_data;
    end
    rd_q <= mem[rd_idx[ffba_pkg::IDX_W-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_bytes <= ffba_pkg::HEADER_RESET;
      heap_lim  <= ffba_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffba_pkg::CFG_HEADER_BYTES: hdr_bytes <= cfg_data[7:0];
        ffba_pkg::CFG_HEAP_LIMIT:   heap_lim  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_size <= request_size;
      req_addr <= release_address;
      req_end  <= {2'b00, bump_ptr} + {26'd0, hdr_bytes} + {10'd0, request_size};
    end
  end

  // sequencer and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      data_address <= '0;
      status       <= ffba_pkg::ST_REUSED;
      blk_count    <= '0;
      bump_ptr     <= '0;
      free_bits    <= '0;
      rd_idx       <= '0;
      chk_idx      <= '0;
      chk_valid    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          chk_valid <= 1'b0;
          rd_idx    <= '0;
          if (start) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          chk_valid <= issue;
          chk_idx   <= rd_idx[ffba_pkg::IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (hit) begin
            state        <= IDLE;
            done         <= 1'b1;
            status       <= ffba_pkg::ST_REUSED;
            free_bits[chk_idx] <= req_mode;
            data_address <= req_mode ? 32'd0 : rd_data_addr;
          end else if (scan_miss) begin
            state <= IDLE;
            done  <= 1'b1;
            if (req_mode) begin
              status       <= ffba_pkg::ST_NOT_FOUND;
              data_address <= '0;
            end else if (!append_ok) begin
              status       <= ffba_pkg::ST_NO_SPACE;
              data_address <= '0;
            end else begin
              status       <= ffba_pkg::ST_APPENDED;
              data_address <= bump_ptr + {24'd0, hdr_bytes};
              free_bits[blk_count[ffba_pkg::IDX_W-1:0]] <= 1'b0;
              blk_count    <= blk_count + 1'b1;
              bump_ptr     <= req_end[31:0];
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    blk_count <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
    else $error("block count beyond table depth");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    append_ok |=> blk_count == $past(blk_count) + 1'b1)
    else $error("append did not grow the table");
  a_chk_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> state == SCAN)
    else $error("entry check outside table walk");
`endif

endmodule
